[src/ipv4fhg_pkg.sv]
// Shared constants and types for the IPv4 fragment header generator.
package ipv4fhg_pkg;

    // Header and fragmentation constants
    localparam logic [15:0] HdrBytes    = 16'd20;
    localparam logic [15:0] MinMtu      = 16'd68;
    localparam logic [15:0] MaxBytes    = 16'd65515;
    localparam logic [15:0] VerIhl      = 16'h4500;

    // Reset values of the configuration registers
    localparam logic [15:0] MtuReset    = 16'd1500;
    localparam logic [7:0]  TtlReset    = 8'd255;
    localparam logic [7:0]  ProtoReset  = 8'd6;

    localparam int CfgIdxW = 3;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_LINK_MTU       = 3'd0,
        REG_SOURCE_ADDRESS = 3'd1,
        REG_DEST_ADDRESS   = 3'd2,
        REG_HOP_LIMIT      = 3'd3,
        REG_UPPER_PROTOCOL = 3'd4,
        REG_SERVICE_TYPE   = 3'd5
    } cfg_reg_t;

    // Input commands
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_NEXT  = 1'b1
    } cmd_t;

    // One fragment descriptor
    typedef struct packed {
        logic [15:0] header_checksum;
        logic [15:0] total_length;
        logic        more_fragments;
        logic [12:0] piece_offset;
        logic [15:0] piece_bytes;
    } frag_desc_t;

endpackage

[src/ipv4_fragment_header_generator_top.sv]
// IPv4 fragment header generator: input register, descriptor logic, result register.
//
// A transfer with tuser = 0 (start) opens a datagram with the length and identification
// in tdata; it gives no result. Each transfer with tuser = 1 (next) gives one fragment
// descriptor, or an error result (m_tuser = 1, all other fields zero) when nothing is
// pending. Items pass an input register and then one stage of descriptor logic into the
// result register, so one item is taken per cycle unless a next meets a stalled result
// register; the result register holds while m_tready is low and the input
// register fills behind it. The MTU-derived fragment size and the configuration part of
// the header checksum are kept in registers loaded from the values going into the
// configuration registers, so both change on the same edge. Configuration writes are
// taken on any cycle (cfg_ready is always high).
module ipv4_fragment_header_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ipv4fhg_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] datagram_bytes, [31:16] ident
    input  logic        s_tuser,   // [0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] piece_bytes, [28:16] piece_offset,
                                   // [29] more_fragments, [45:30] total_length,
                                   // [61:46] header_checksum, [63:62] zero
    output logic        m_tuser,   // [0] no_datagram
    output logic        m_tlast    // last fragment of the datagram
);

    // Configuration registers
    logic [15:0] link_mtu_reg;
    logic [31:0] source_address_reg;
    logic [31:0] dest_address_reg;
    logic [7:0]  hop_limit_reg;
    logic [7:0]  upper_protocol_reg;
    logic [7:0]  service_type_reg;
    logic [15:0] link_mtu_next;
    logic [31:0] source_address_next;
    logic [31:0] dest_address_next;
    logic [7:0]  hop_limit_next;
    logic [7:0]  upper_protocol_next;
    logic [7:0]  service_type_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        link_mtu_next       = link_mtu_reg;
        source_address_next = source_address_reg;
        dest_address_next   = dest_address_reg;
        hop_limit_next      = hop_limit_reg;
        upper_protocol_next = upper_protocol_reg;
        service_type_next   = service_type_reg;
        if (!aresetn) begin
            link_mtu_next       = ipv4fhg_pkg::MtuReset;
            source_address_next = '0;
            dest_address_next   = '0;
            hop_limit_next      = ipv4fhg_pkg::TtlReset;
            upper_protocol_next = ipv4fhg_pkg::ProtoReset;
            service_type_next   = '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ipv4fhg_pkg::REG_LINK_MTU:       link_mtu_next       = cfg_data[15:0];
                ipv4fhg_pkg::REG_SOURCE_ADDRESS: source_address_next = cfg_data;
                ipv4fhg_pkg::REG_DEST_ADDRESS:   dest_address_next   = cfg_data;
                ipv4fhg_pkg::REG_HOP_LIMIT:      hop_limit_next      = cfg_data[7:0];
                ipv4fhg_pkg::REG_UPPER_PROTOCOL: upper_protocol_next = cfg_data[7:0];
                ipv4fhg_pkg::REG_SERVICE_TYPE:   service_type_next   = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        link_mtu_reg       <= link_mtu_next;
        source_address_reg <= source_address_next;
        dest_address_reg   <= dest_address_next;
        hop_limit_reg      <= hop_limit_next;
        upper_protocol_reg <= upper_protocol_next;
        service_type_reg   <= service_type_next;
    end

    // Values derived from configuration, loaded together with the registers
    logic [15:0] room_reg;      // room after the header, clamped MTU less 20
    logic [15:0] full_len_reg;  // room rounded down to whole 8-byte blocks
    logic [15:0] full_tot_reg;  // total length of a non-final fragment
    logic [18:0] cfg_sum_reg;   // sum of the header words set by configuration
    logic [15:0] mtu_eff;
    logic [15:0] room_next;

    always_comb begin
        mtu_eff   = (link_mtu_next < ipv4fhg_pkg::MinMtu) ? ipv4fhg_pkg::MinMtu
                                                          : link_mtu_next;
        room_next = mtu_eff - ipv4fhg_pkg::HdrBytes;
    end

    always_ff @(posedge aclk) begin
        room_reg     <= room_next;
        full_len_reg <= {room_next[15:3], 3'b000};
        full_tot_reg <= {room_next[15:3], 3'b000} + ipv4fhg_pkg::HdrBytes;
        cfg_sum_reg  <= {3'b000, ipv4fhg_pkg::VerIhl | {8'h00, service_type_next}}
                      + {3'b000, hop_limit_next, upper_protocol_next}
                      + {3'b000, source_address_next[31:16]}
                      + {3'b000, source_address_next[15:0]}
                      + {3'b000, dest_address_next[31:16]}
                      + {3'b000, dest_address_next[15:0]};
    end

    // Input register
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [15:0] in_bytes_reg;
    logic [15:0] in_ident_reg;
    logic        advance;

    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser;
            in_bytes_reg <= s_tdata[15:0];
            in_ident_reg <= s_tdata[31:16];
        end
    end

    // Datagram state
    logic [15:0] bytes_left_reg;
    logic [12:0] next_offset_reg;
    logic [15:0] current_ident_reg;

    // A start is consumed at once; a next needs room in the result register
    logic is_next;
    assign is_next = (in_cmd_reg == ipv4fhg_pkg::CMD_NEXT);
    assign advance = in_valid_reg && (!is_next || !m_tvalid || m_tready);

    // Descriptor logic
    logic               fin;
    logic               empty;
    logic [15:0]        len;
    logic [15:0]        tot;
    logic [15:0]        flags_off;
    logic [19:0]        sum;
    logic [16:0]        fold1;
    logic [15:0]        fold2;
    ipv4fhg_pkg::frag_desc_t desc;

    always_comb begin
        empty     = (bytes_left_reg == 16'd0);
        fin       = (bytes_left_reg <= room_reg);
        len       = fin ? bytes_left_reg : full_len_reg;
        tot       = fin ? (bytes_left_reg + ipv4fhg_pkg::HdrBytes) : full_tot_reg;
        flags_off = {2'b00, !fin, next_offset_reg};
        sum       = {1'b0, cfg_sum_reg} + {4'h0, tot} + {4'h0, current_ident_reg}
                  + {4'h0, flags_off};
        // end-around carry, twice covers the width
        fold1     = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
        fold2     = fold1[15:0] + {15'd0, fold1[16]};
        desc.piece_bytes     = len;
        desc.piece_offset    = next_offset_reg;
        desc.more_fragments  = !fin;
        desc.total_length    = tot;
        desc.header_checksum = ~fold2;
        if (empty) begin
            desc = '0;
        end
    end

    // State update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg    <= '0;
            next_offset_reg   <= '0;
            current_ident_reg <= '0;
        end else if (advance) begin
            if (!is_next) begin
                bytes_left_reg    <= (in_bytes_reg > ipv4fhg_pkg::MaxBytes)
                                     ? ipv4fhg_pkg::MaxBytes : in_bytes_reg;
                next_offset_reg   <= '0;
                current_ident_reg <= in_ident_reg;
            end else if (!empty) begin
                bytes_left_reg  <= bytes_left_reg - len;
                next_offset_reg <= next_offset_reg + len[15:3];
            end
        end
    end

    // Result register
    logic                    out_valid_reg;
    ipv4fhg_pkg::frag_desc_t out_desc_reg;
    logic                    out_err_reg;
    logic                    out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_next) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && is_next) begin
            out_desc_reg <= desc;
            out_err_reg  <= empty;
            out_last_reg <= fin && !empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_desc_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 64'd0 && !m_tlast))
        else $error("error result carries nonzero fields");

    a_last_vs_mf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast == !out_desc_reg.more_fragments))
        else $error("last and more_fragments disagree");

    a_total_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
        (out_desc_reg.total_length == out_desc_reg.piece_bytes + ipv4fhg_pkg::HdrBytes))
        else $error("total length does not match fragment bytes");

    a_bytes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= ipv4fhg_pkg::MaxBytes)
        else $error("pending byte count out of range");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule
